/* rtl/sbc_pkg.sv */
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types, constants and the color shading function for the scaled
// palette sprite blit core.
// ----------------------------------------------------------------------------
`default_nettype none

package sbc_pkg;

  // Default replication limit
  localparam int SBC_MAX_SCALE = 8;

  // Field widths
  localparam int SRC_W   = 10;
  localparam int IDX_W   = 8;
  localparam int DST_W   = 11;
  localparam int OFF_W   = 12;
  localparam int SCL_W   = 4;
  localparam int GRP_W   = 5;
  localparam int CLIP_W  = 12;
  localparam int NIB_W   = 4;
  localparam int STEP_W  = 3;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [CLIP_W-1:0] CLIP_LIMIT    = 12'd2048;
  localparam logic [IDX_W-1:0]  COLOR_CLIPPED = 8'h0F;

  // Register indexes (byte address / 4)
  localparam logic [2:0] REG_OFFSET_X   = 3'd0;
  localparam logic [2:0] REG_OFFSET_Y   = 3'd1;
  localparam logic [2:0] REG_SCALE      = 3'd2;
  localparam logic [2:0] REG_SHADE      = 3'd3;
  localparam logic [2:0] REG_GROUP      = 3'd4;
  localparam logic [2:0] REG_CLIP_W     = 3'd5;
  localparam logic [2:0] REG_CLIP_H     = 3'd6;

  // Microprogram addresses
  typedef logic [STEP_W-1:0] step_t;
  localparam step_t ADDR_IDLE = 3'd0;
  localparam step_t ADDR_MUL  = 3'd1;
  localparam step_t ADDR_SUM  = 3'd2;
  localparam step_t ADDR_CLIP = 3'd3;
  localparam step_t ADDR_EMIT = 3'd4;

  // Jump conditions
  typedef enum logic [2:0] {
    C_ALWAYS = 3'd0,
    C_IN     = 3'd1,
    C_SKIP   = 3'd2,
    C_EMPTY  = 3'd3,
    C_DONE   = 3'd4
  } cond_t;

  // One control word: datapath strobes, condition, taken / not-taken address
  typedef struct packed {
    logic  in_ready;
    logic  ld_mul;
    logic  ld_sum;
    logic  ld_clip;
    logic  emit;
    cond_t cond;
    step_t t_addr;
    step_t f_addr;
  } ucode_t;

  // Datapath status back to the sequencer
  typedef struct packed {
    logic skip;
    logic empty;
    logic done;
  } dp_status_t;

  // Configuration register file
  typedef struct packed {
    logic [OFF_W-1:0]  off_x;
    logic [OFF_W-1:0]  off_y;
    logic [SCL_W-1:0]  scale;
    logic [IDX_W-1:0]  shade;
    logic [GRP_W-1:0]  group;
    logic [CLIP_W-1:0] clip_w;
    logic [CLIP_W-1:0] clip_h;
  } cfg_t;

  // Shade a palette index; group change or nibble overflow gives the clip color
  function automatic logic [IDX_W-1:0] shade_color(input logic [IDX_W-1:0] idx,
                                                   input logic [IDX_W-1:0] shade,
                                                   input logic [GRP_W-1:0] grp);
    logic [IDX_W-1:0] s;
    logic [NIB_W-1:0] g;
    g = NIB_W'(grp - 5'd1);
    if (grp != '0) begin
      s = {{NIB_W{1'b0}}, idx[NIB_W-1:0]} + shade;
      shade_color = (s[IDX_W-1:NIB_W] != '0) ? COLOR_CLIPPED : {g, s[NIB_W-1:0]};
    end else begin
      s = idx + shade;
      shade_color = (s[IDX_W-1:NIB_W] != idx[IDX_W-1:NIB_W]) ? COLOR_CLIPPED : s;
    end
  endfunction

endpackage

`default_nettype wire

/* rtl/sbc_ucode_rom.sv */
// ----------------------------------------------------------------------------
// sbc_ucode_rom
// Control store of the blit sequencer: one control word per step.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_ucode_rom
  import sbc_pkg::*;
(
  input  wire step_t  step,
  output ucode_t      word
);

  // Program:
  //   IDLE : take a pixel, wait here until one arrives
  //   MUL  : scale source coordinates, shade color; transparent or zero scale -> IDLE
  //   SUM  : add offsets, form block corners
  //   CLIP : clip block to destination; nothing left -> IDLE
  //   EMIT : one write per free output slot until the last one
  always_comb begin
    word = '{in_ready: 1'b0, ld_mul: 1'b0, ld_sum: 1'b0, ld_clip: 1'b0,
             emit: 1'b0, cond: C_ALWAYS, t_addr: ADDR_IDLE, f_addr: ADDR_IDLE};
    unique case (step)
      ADDR_IDLE: begin
        word.in_ready = 1'b1;
        word.cond     = C_IN;
        word.t_addr   = ADDR_MUL;
        word.f_addr   = ADDR_IDLE;
      end
      ADDR_MUL: begin
        word.ld_mul   = 1'b1;
        word.cond     = C_SKIP;
        word.t_addr   = ADDR_IDLE;
        word.f_addr   = ADDR_SUM;
      end
      ADDR_SUM: begin
        word.ld_sum   = 1'b1;
        word.cond     = C_ALWAYS;
        word.t_addr   = ADDR_CLIP;
      end
      ADDR_CLIP: begin
        word.ld_clip  = 1'b1;
        word.cond     = C_EMPTY;
        word.t_addr   = ADDR_IDLE;
        word.f_addr   = ADDR_EMIT;
      end
      ADDR_EMIT: begin
        word.emit     = 1'b1;
        word.cond     = C_DONE;
        word.t_addr   = ADDR_IDLE;
        word.f_addr   = ADDR_EMIT;
      end
      default: begin
        word.cond     = C_ALWAYS;
        word.t_addr   = ADDR_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

/* rtl/sbc_datapath.sv */
// ----------------------------------------------------------------------------
// sbc_datapath
// Pixel registers, coordinate scaling, clipping, write counters and the
// output register, all driven by the sequencer's control word.
// ----------------------------------------------------------------------------
`default_nettype none

module sbc_datapath
  import sbc_pkg::*;
#(
  parameter int MAX_SCALE = SBC_MAX_SCALE
)(
  input  wire                clk,
  input  wire                rst,
  input  wire ucode_t        ctrl,
  input  wire                in_fire,
  input  wire [SRC_W-1:0]    in_col,
  input  wire [SRC_W-1:0]    in_row,
  input  wire [IDX_W-1:0]    in_idx,
  input  wire cfg_t          cfg,
  output dp_status_t         status,
  output logic               m_tvalid,
  input  wire                m_tready,
  output logic [DATA_W-1:0]  m_tdata,   // dst_col[10:0], dst_row[21:11], color[29:22]
  output logic               m_tlast
);

  localparam int SCW = $clog2(MAX_SCALE + 1);
  localparam int PW  = SRC_W + SCW;
  localparam int XW  = PW + 2;

  // Pixel registers
  logic [SRC_W-1:0] col;
  logic [SRC_W-1:0] row;
  logic [IDX_W-1:0] idx;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      col <= in_col;
      row <= in_row;
      idx <= in_idx;
    end
  end

  // Effective scale, clamped to MAX_SCALE
  logic [4:0]     scale_sel;
  logic [SCW-1:0] sc;

  always_comb begin
    scale_sel = ({1'b0, cfg.scale} > 5'(MAX_SCALE)) ? 5'(MAX_SCALE) : {1'b0, cfg.scale};
    sc        = scale_sel[SCW-1:0];
  end

  assign status.skip = (idx == '0) || (cfg.scale == '0);

  // Scale step
  logic [PW-1:0]    colsc;
  logic [PW-1:0]    rowsc;
  logic [IDX_W-1:0] color;

  always_ff @(posedge clk) begin
    if (ctrl.ld_mul) begin
      colsc <= {{SCW{1'b0}}, col} * {{SRC_W{1'b0}}, sc};
      rowsc <= {{SCW{1'b0}}, row} * {{SRC_W{1'b0}}, sc};
      color <= shade_color(idx, cfg.shade, cfg.group);
    end
  end

  // Offset step: block corners
  logic signed [XW-1:0] offx_ext;
  logic signed [XW-1:0] offy_ext;
  logic signed [XW-1:0] sc_m1;
  logic signed [XW-1:0] x0;
  logic signed [XW-1:0] x1;
  logic signed [XW-1:0] y0;
  logic signed [XW-1:0] y1;

  always_comb begin
    offx_ext = {{(XW-OFF_W){cfg.off_x[OFF_W-1]}}, cfg.off_x};
    offy_ext = {{(XW-OFF_W){cfg.off_y[OFF_W-1]}}, cfg.off_y};
    sc_m1    = {{(XW-SCW){1'b0}}, sc} - XW'(1);
  end

  always_ff @(posedge clk) begin
    if (ctrl.ld_sum) begin
      x0 <= offx_ext + {2'b00, colsc};
      x1 <= offx_ext + {2'b00, colsc} + sc_m1;
      y0 <= offy_ext + {2'b00, rowsc};
      y1 <= offy_ext + {2'b00, rowsc} + sc_m1;
    end
  end

  // Clip step
  logic [CLIP_W-1:0]    cw;
  logic [CLIP_W-1:0]    ch;
  logic signed [XW-1:0] cw_m1;
  logic signed [XW-1:0] ch_m1;
  logic signed [XW-1:0] xs_full;
  logic signed [XW-1:0] xe_full;
  logic signed [XW-1:0] ys_full;
  logic signed [XW-1:0] ye_full;

  always_comb begin
    cw      = (cfg.clip_w > CLIP_LIMIT) ? CLIP_LIMIT : cfg.clip_w;
    ch      = (cfg.clip_h > CLIP_LIMIT) ? CLIP_LIMIT : cfg.clip_h;
    cw_m1   = {{(XW-CLIP_W){1'b0}}, cw} - XW'(1);
    ch_m1   = {{(XW-CLIP_W){1'b0}}, ch} - XW'(1);
    xs_full = x0[XW-1] ? '0 : x0;
    ys_full = y0[XW-1] ? '0 : y0;
    xe_full = (x1 > cw_m1) ? cw_m1 : x1;
    ye_full = (y1 > ch_m1) ? ch_m1 : y1;
  end

  assign status.empty = (xs_full > xe_full) || (ys_full > ye_full);

  // Write rectangle and counters
  logic [DST_W-1:0] xs;
  logic [DST_W-1:0] xe;
  logic [DST_W-1:0] ye;
  logic [DST_W-1:0] x;
  logic [DST_W-1:0] y;
  logic             fire;
  logic             last_w;

  assign fire        = ctrl.emit && (!m_tvalid || m_tready);
  assign last_w      = (x == xe) && (y == ye);
  assign status.done = fire && last_w;

  always_ff @(posedge clk) begin
    if (ctrl.ld_clip) begin
      xs <= xs_full[DST_W-1:0];
      xe <= xe_full[DST_W-1:0];
      ye <= ye_full[DST_W-1:0];
      x  <= xs_full[DST_W-1:0];
      y  <= ys_full[DST_W-1:0];
    end else if (fire) begin
      if (x == xe) begin
        x <= xs;
        y <= y + DST_W'(1);
      end else begin
        x <= x + DST_W'(1);
      end
    end
  end

  // Output register
  logic [DST_W-1:0] o_col;
  logic [DST_W-1:0] o_row;
  logic [IDX_W-1:0] o_color;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      o_col   <= x;
      o_row   <= y;
      o_color <= color;
      m_tlast <= last_w;
    end
  end

  assign m_tdata = {{(DATA_W-2*DST_W-IDX_W){1'b0}}, o_color, o_row, o_col};

endmodule

`default_nettype wire

/* rtl/scaled_palette_sprite_blit_core.sv */
// Flow: an accepted pixel steps through MUL, SUM and CLIP, then EMIT issues one
// write per surviving destination pixel, repeating while the output stalls; the
// sequencer takes one microprogram step a cycle and takes no new pixel until it
// is back in IDLE. Transparent pixels return after MUL, fully clipped ones after CLIP.
// Reset: synchronous, active high; registers return to their defaults
// (scale 1, clip 2048 x 2048, others 0) and the sequencer to its idle step.
// ----------------------------------------------------------------------------
// scaled_palette_sprite_blit_core
// Nearest-neighbor scaled, clipped and shaded palette sprite blit: each
// source pixel becomes a block of destination writes.
// ----------------------------------------------------------------------------
`default_nettype none

module scaled_palette_sprite_blit_core
  import sbc_pkg::*;
#(
  parameter int MAX_SCALE = SBC_MAX_SCALE
)(
  input  wire                clk,
  input  wire                rst,
  // pixel input
  input  wire                s_tvalid,
  output logic               s_tready,
  input  wire [DATA_W-1:0]   s_tdata,   // src_col[9:0], src_row[19:10], pixel_index[27:20]
  // write output
  output logic               m_tvalid,
  input  wire                m_tready,
  output logic [DATA_W-1:0]  m_tdata,   // dst_col[10:0], dst_row[21:11], color[29:22]
  output logic               m_tlast,   // last write of a pixel
  // configuration
  input  wire                psel,
  input  wire                penable,
  input  wire                pwrite,
  input  wire [ADDR_W-1:0]   paddr,
  input  wire [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  // Configuration registers
  cfg_t       cfg;
  logic [2:0] reg_idx;
  logic       wr_en;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign wr_en   = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.off_x  <= '0;
      cfg.off_y  <= '0;
      cfg.scale  <= SCL_W'(1);
      cfg.shade  <= '0;
      cfg.group  <= '0;
      cfg.clip_w <= CLIP_LIMIT;
      cfg.clip_h <= CLIP_LIMIT;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_OFFSET_X: cfg.off_x  <= pwdata[OFF_W-1:0];
        REG_OFFSET_Y: cfg.off_y  <= pwdata[OFF_W-1:0];
        REG_SCALE:    cfg.scale  <= pwdata[SCL_W-1:0];
        REG_SHADE:    cfg.shade  <= pwdata[IDX_W-1:0];
        REG_GROUP:    cfg.group  <= pwdata[GRP_W-1:0];
        REG_CLIP_W:   cfg.clip_w <= pwdata[CLIP_W-1:0];
        REG_CLIP_H:   cfg.clip_h <= pwdata[CLIP_W-1:0];
        default: ;
      endcase
    end
  end

  // Register read-back
  always_comb begin
    unique case (reg_idx)
      REG_OFFSET_X: prdata = DATA_W'(cfg.off_x);
      REG_OFFSET_Y: prdata = DATA_W'(cfg.off_y);
      REG_SCALE:    prdata = DATA_W'(cfg.scale);
      REG_SHADE:    prdata = DATA_W'(cfg.shade);
      REG_GROUP:    prdata = DATA_W'(cfg.group);
      REG_CLIP_W:   prdata = DATA_W'(cfg.clip_w);
      REG_CLIP_H:   prdata = DATA_W'(cfg.clip_h);
      default:      prdata = '0;
    endcase
  end

  // Sequencer: step counter, control store, branch condition
  step_t      step;
  step_t      step_next;
  ucode_t     ctrl;
  dp_status_t status;
  logic       in_fire;
  logic       taken;

  sbc_ucode_rom u_rom (
    .step (step),
    .word (ctrl)
  );

  assign s_tready = ctrl.in_ready;
  assign in_fire  = s_tvalid && s_tready;

  always_comb begin
    unique case (ctrl.cond)
      C_ALWAYS: taken = 1'b1;
      C_IN:     taken = in_fire;
      C_SKIP:   taken = status.skip;
      C_EMPTY:  taken = status.empty;
      C_DONE:   taken = status.done;
      default:  taken = 1'b1;
    endcase
    step_next = taken ? ctrl.t_addr : ctrl.f_addr;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= ADDR_IDLE;
    end else begin
      step <= step_next;
    end
  end

  // Datapath
  sbc_datapath #(
    .MAX_SCALE (MAX_SCALE)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctrl     (ctrl),
    .in_fire  (in_fire),
    .in_col   (s_tdata[SRC_W-1:0]),
    .in_row   (s_tdata[2*SRC_W-1:SRC_W]),
    .in_idx   (s_tdata[2*SRC_W+IDX_W-1:2*SRC_W]),
    .cfg      (cfg),
    .status   (status),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  // Checks
  a_in_starts_program: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> step == ADDR_MUL)
    else $error("accepted pixel did not start the microprogram");

  a_last_returns_idle: assert property (@(posedge clk) disable iff (rst)
    (step == ADDR_EMIT && status.done) |=> step == ADDR_IDLE)
    else $error("sequencer did not return to idle after the last write");

  a_skip_no_write: assert property (@(posedge clk) disable iff (rst)
    (step == ADDR_MUL && status.skip) |=> !$rose(m_tvalid))
    else $error("transparent pixel produced a write");

  a_emit_tlast: assert property (@(posedge clk) disable iff (rst)
    (step == ADDR_EMIT && status.done) |=> m_tvalid && m_tlast)
    else $error("final write of a pixel not marked last");

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for scaled_palette_sprite_blit_core. Source pixels go
// in on the stream slave side. A scoreboard predicts each pixel's block of
// clipped, shaded destination writes and checks the master-side beats in
// order. The bench runs directed corner cases first, then random register
// settings and random pixels, with random stalls on both sides and a long
// receiver hold-off that backs the core up.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sbc_pkg::*;

  localparam int          SETTLE_CYCLES = 16;
  localparam int          HOLD_CYCLES   = 300;
  localparam int          TARGET_PIXELS = 450;
  localparam int unsigned CYCLE_LIMIT   = 5_000_000;

  // One destination write as it leaves the core
  typedef struct packed {
    logic [DST_W-1:0] dst_col;
    logic [DST_W-1:0] dst_row;
    logic [IDX_W-1:0] color;
    logic             last;
  } blit_write_t;

  // --------------------------------------------------------------------------
  // Scoreboard: register copy, write predictor, in-order checker
  // --------------------------------------------------------------------------
  class blit_scoreboard;
    logic signed [OFF_W-1:0] off_x, off_y;
    logic [SCL_W-1:0]        scale;
    logic [IDX_W-1:0]        shade;
    logic [GRP_W-1:0]        group;
    logic [CLIP_W-1:0]       clip_w, clip_h;
    blit_write_t             pending_writes[$];
    int unsigned             mismatches;
    int unsigned             writes_checked;

    function new();
      off_x          = '0;
      off_y          = '0;
      scale          = SCL_W'(1);
      shade          = '0;
      group          = '0;
      clip_w         = CLIP_LIMIT;
      clip_h         = CLIP_LIMIT;
      mismatches     = 0;
      writes_checked = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [DATA_W-1:0] value);
      case (idx)
        REG_OFFSET_X: off_x = value[OFF_W-1:0];
        REG_OFFSET_Y: off_y = value[OFF_W-1:0];
        REG_SCALE:    scale = value[SCL_W-1:0];
        REG_SHADE:    shade = value[IDX_W-1:0];
        REG_GROUP:    group = value[GRP_W-1:0];
        REG_CLIP_W:   clip_w = value[CLIP_W-1:0];
        REG_CLIP_H:   clip_h = value[CLIP_W-1:0];
        default: ;
      endcase
    endfunction

    // scale saturates at the core's limit
    function int eff_scale();
      return (int'(scale) > SBC_MAX_SCALE) ? SBC_MAX_SCALE : int'(scale);
    endfunction

    // clip sizes beyond the 11-bit destination space act as 2048
    function int eff_clip(logic [CLIP_W-1:0] c);
      return (c > CLIP_LIMIT) ? int'(CLIP_LIMIT) : int'(c);
    endfunction

    function logic [IDX_W-1:0] shaded(logic [IDX_W-1:0] idx);
      logic [IDX_W-1:0] sum;
      if (group != '0) begin
        // replace mode: shade the low nibble only, new group on top
        sum = {4'h0, idx[3:0]} + shade;
        if (sum[7:4] != 4'h0) return COLOR_CLIPPED;
        return {4'(group - 5'd1), sum[3:0]};
      end
      sum = idx + shade;
      if (sum[7:4] != idx[7:4]) return COLOR_CLIPPED;
      return sum;
    endfunction

    // Expand one accepted pixel into its surviving block writes
    function void note_pixel(logic [SRC_W-1:0] col, logic [SRC_W-1:0] row,
                             logic [IDX_W-1:0] idx);
      blit_write_t      blk[$];
      int               sc, cw, ch, x0, y0, dx, dy;
      logic [IDX_W-1:0] c;
      sc = eff_scale();
      if (idx == '0 || sc == 0) return;
      cw = eff_clip(clip_w);
      ch = eff_clip(clip_h);
      c  = shaded(idx);
      x0 = int'(off_x) + int'(col) * sc;
      y0 = int'(off_y) + int'(row) * sc;
      for (int j = 0; j < sc; j++) begin
        dy = y0 + j;
        if (dy < 0 || dy >= ch) continue;
        for (int i = 0; i < sc; i++) begin
          dx = x0 + i;
          if (dx < 0 || dx >= cw) continue;
          blk.push_back('{dst_col: DST_W'(dx), dst_row: DST_W'(dy), color: c, last: 1'b0});
        end
      end
      if (blk.size() > 0) blk[blk.size()-1].last = 1'b1;
      foreach (blk[k]) pending_writes.push_back(blk[k]);
    endfunction

    function void check_write(logic [DATA_W-1:0] data, logic tlast);
      blit_write_t      exp_w;
      logic [DST_W-1:0] got_col, got_row;
      logic [IDX_W-1:0] got_color;
      got_col   = data[DST_W-1:0];
      got_row   = data[2*DST_W-1:DST_W];
      got_color = data[2*DST_W+IDX_W-1:2*DST_W];
      if (pending_writes.size() == 0) begin
        $error("unexpected write beat: col %0d row %0d color 0x%02h",
               got_col, got_row, got_color);
        mismatches++;
        return;
      end
      exp_w = pending_writes.pop_front();
      writes_checked++;
      if (got_col != exp_w.dst_col) begin
        $error("dst_col: expected %0d, got %0d", exp_w.dst_col, got_col);
        mismatches++;
      end
      if (got_row != exp_w.dst_row) begin
        $error("dst_row: expected %0d, got %0d", exp_w.dst_row, got_row);
        mismatches++;
      end
      if (got_color != exp_w.color) begin
        $error("color: expected 0x%02h, got 0x%02h", exp_w.color, got_color);
        mismatches++;
      end
      if (tlast != exp_w.last) begin
        $error("last: expected %0d, got %0d", exp_w.last, tlast);
        mismatches++;
      end
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // DUT and signals
  // --------------------------------------------------------------------------
  logic              clk, rst;
  logic              s_tvalid, s_tready;
  logic [DATA_W-1:0] s_tdata;   // src_col[9:0], src_row[19:10], pixel_index[27:20]
  logic              m_tvalid, m_tready;
  logic [DATA_W-1:0] m_tdata;   // dst_col[10:0], dst_row[21:11], color[29:22]
  logic              m_tlast;
  logic              psel, penable, pwrite, pready;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata, prdata;

  scaled_palette_sprite_blit_core DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  blit_scoreboard sb;
  bit             tx_calm, rx_calm, hold_req;
  int unsigned    pixels_sent, visible_sent, settings_used;

  // Clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Watchdog
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("CHECK FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Monitors: both handshakes sampled at the rising edge
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst && s_tvalid && s_tready)
      sb.note_pixel(s_tdata[SRC_W-1:0], s_tdata[2*SRC_W-1:SRC_W],
                    s_tdata[2*SRC_W+IDX_W-1:2*SRC_W]);
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_write(m_tdata, m_tlast);
  end

  // --------------------------------------------------------------------------
  // Gap lengths: mostly none or short, a few long
  // --------------------------------------------------------------------------
  function automatic int rand_gap(bit calm);
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Receiver: random stalls, plus the long hold-off on request
  initial begin : write_sink
    int stall_left;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req   = 1'b0;
        stall_left = HOLD_CYCLES;
      end
      if (stall_left > 0) begin
        m_tready <= 1'b0;
        stall_left--;
      end else begin
        m_tready   <= 1'b1;
        stall_left = rand_gap(rx_calm);
      end
    end
  end

  // --------------------------------------------------------------------------
  // Drivers
  // --------------------------------------------------------------------------
  task automatic apb_write(input logic [2:0] reg_idx, input logic [DATA_W-1:0] value);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_idx, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    sb.write_reg(reg_idx, value);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_all(input int ox, input int oy, input int sc, input int sh,
                         input int grp, input int cw, input int ch);
    apb_write(REG_OFFSET_X, DATA_W'(ox));
    apb_write(REG_OFFSET_Y, DATA_W'(oy));
    apb_write(REG_SCALE, DATA_W'(sc));
    apb_write(REG_SHADE, DATA_W'(sh));
    apb_write(REG_GROUP, DATA_W'(grp));
    apb_write(REG_CLIP_W, DATA_W'(cw));
    apb_write(REG_CLIP_H, DATA_W'(ch));
    settings_used++;
  endtask

  task automatic send_pixel(input logic [SRC_W-1:0] col, input logic [SRC_W-1:0] row,
                            input logic [IDX_W-1:0] idx);
    int gap;
    @(negedge clk);
    s_tdata  <= {4'h0, idx, row, col};
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    pixels_sent++;
    if (idx != '0 && sb.eff_scale() != 0) visible_sent++;
    gap = rand_gap(tx_calm);
    if (gap > 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic end_burst();
    @(negedge clk);
    s_tvalid <= 1'b0;
  endtask

  // Wait for every predicted write, then let a transparent or clipped pixel finish
  task automatic drain();
    while (sb.pending_writes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Random pixels and settings
  // --------------------------------------------------------------------------
  // Source coordinate aimed mostly at the visible window
  function automatic logic [SRC_W-1:0] aim(int off, int lim);
    int sc, t, v;
    sc = sb.eff_scale();
    if (sc == 0) sc = 1;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return SRC_W'($urandom_range(0, 1023));
      default: begin
        t = int'($urandom_range(0, lim + 16)) - 8;
        v = (t - off) / sc;
        if (v < 0) v = 0;
        if (v > 1023) v = 1023;
        return SRC_W'(v);
      end
    endcase
  endfunction

  task automatic send_random_pixel();
    logic [SRC_W-1:0] col, row;
    logic [IDX_W-1:0] idx;
    int               r;
    col = aim(int'(sb.off_x), sb.eff_clip(sb.clip_w));
    row = aim(int'(sb.off_y), sb.eff_clip(sb.clip_h));
    r   = $urandom_range(0, 19);
    if (r < 3) idx = '0;
    else if (r == 3) idx = 8'hFF;
    else idx = IDX_W'($urandom_range(1, 255));
    send_pixel(col, row, idx);
  endtask

  function automatic int rand_offset();
    case ($urandom_range(0, 9))
      0: return -2048;
      1: return 2047;
      2, 3, 4: return $urandom_range(0, 4095) - 2048;
      default: return int'($urandom_range(0, 60)) - 20;
    endcase
  endfunction

  function automatic int rand_scale();
    int r;
    r = $urandom_range(0, 99);
    if (r < 3) return 0;
    if (r < 10) return $urandom_range(9, 15);
    if (r < 30) return $urandom_range(5, 8);
    return $urandom_range(1, 4);
  endfunction

  function automatic int rand_clip();
    case ($urandom_range(0, 19))
      0: return 0;
      1: return 4095;
      2: return $urandom_range(2049, 4095);
      3: return 2048;
      4, 5: return $urandom_range(1, 16);
      6: return 1;
      default: return $urandom_range(1, 2048);
    endcase
  endfunction

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin : main
    int n;
    bit pressure_done;
    sb            = new();
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    m_tready      = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    tx_calm       = 1'b0;
    rx_calm       = 1'b0;
    hold_req      = 1'b0;
    pixels_sent   = 0;
    visible_sent  = 0;
    settings_used = 0;
    pressure_done = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset settings: field extremes and a transparent pixel
    send_pixel(10'd0, 10'd0, 8'h01);
    send_pixel(10'd1023, 10'd1023, 8'hFF);
    send_pixel(10'd3, 10'd4, 8'h00);
    send_pixel(10'd1023, 10'd0, 8'h7F);
    send_pixel(10'd0, 10'd1023, 8'hF0);
    end_burst();
    drain();

    // Max scale, negative offsets clip left/top, shade crosses the group
    set_all(-3, -5, 8, 8'h10, 0, 2048, 2048);
    send_pixel(10'd0, 10'd0, 8'h35);
    send_pixel(10'd1, 10'd1, 8'hF5);
    send_pixel(10'd255, 10'd255, 8'h01);
    send_pixel(10'd600, 10'd0, 8'h22);
    send_pixel(10'd0, 10'd0, 8'h00);
    end_burst();
    drain();

    // Offset extremes at the clip edge, top group with nibble overflow
    set_all(2047, -2046, 2, 3, 16, 2048, 2048);
    send_pixel(10'd0, 10'd1023, 8'h9C);
    send_pixel(10'd0, 10'd1023, 8'h9D);
    send_pixel(10'd1, 10'd1023, 8'h40);
    end_burst();
    drain();

    // Zero scale gives nothing
    set_all(0, 0, 0, 0, 0, 2048, 2048);
    send_pixel(10'd1, 10'd1, 8'h05);
    end_burst();
    drain();

    // Zero clip height gives nothing
    set_all(10, 10, 15, 8'hFF, 31, 4095, 0);
    send_pixel(10'd0, 10'd0, 8'h09);
    end_burst();
    drain();

    // Oversized scale and clip, group beyond 16
    set_all(-2048, 0, 15, 8'hFF, 31, 4095, 4095);
    send_pixel(10'd300, 10'd0, 8'h01);
    send_pixel(10'd300, 10'd2, 8'h21);
    end_burst();
    drain();

    // Random settings, random pixels
    while (pixels_sent < TARGET_PIXELS) begin
      if (!pressure_done && visible_sent > 60) begin
        // receiver holds off while pixels keep coming: the core backs up
        set_all(0, 0, 3, $urandom_range(0, 255), $urandom_range(0, 17), 2048, 2048);
        tx_calm  = 1'b1;
        hold_req = 1'b1;
        for (int k = 0; k < 24; k++)
          send_pixel(SRC_W'($urandom_range(0, 600)), SRC_W'($urandom_range(0, 600)),
                     IDX_W'($urandom_range(1, 255)));
        end_burst();
        drain();
        pressure_done = 1'b1;
      end
      set_all(rand_offset(), rand_offset(), rand_scale(), $urandom_range(0, 255),
              ($urandom_range(0, 1) != 0) ? 0 : $urandom_range(1, 31),
              rand_clip(), rand_clip());
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      n = $urandom_range(20, 50);
      for (int k = 0; k < n; k++) send_random_pixel();
      end_burst();
      drain();
    end

    repeat (40) @(posedge clk);
    $display("Blit run: %0d pixels sent (%0d visible) under %0d register settings",
             pixels_sent, visible_sent, settings_used);
    $display("  %0d write beats checked, %0d mismatches", sb.writes_checked, sb.mismatches);
    if (sb.mismatches == 0 && sb.pending_writes.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
